[sv/mgf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgf_pkg: shared types for the frequent-items unit
// Scan record, cell command and controller state.
// ----------------------------------------------------------------------------
package mgf_pkg;

	// residual counter width, fixed by the result item
	localparam int COUNT_W = 32;
	// stream and candidate value width on the channels
	localparam int PORT_VALUE_W = 32;
	// width of slot counts and indexes in the scan record (up to 63 slots)
	localparam int REC_W = 6;
	// width of the occupancy limit register
	localparam int LIMIT_W = 4;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd15;

	typedef logic [REC_W-1:0] rec_num_t;

	// token handed from cell to cell during a scan
	typedef struct packed {
		logic     hit;
		logic     free_found;
		rec_num_t occ;
		rec_num_t free_idx;
	} scan_rec_t;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_INC,
		OP_CLAIM,
		OP_DEC,
		OP_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		rec_num_t idx;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY,
		ST_DRAIN
	} fsm_state_t;

endpackage

[sv/mgf_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgf channels: stream input and candidate readout
// Valid/ready interfaces carrying one item per handshake.
// ----------------------------------------------------------------------------
interface mgf_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] stream_value;
	logic        end_of_stream;

	modport source (output valid, output stream_value, output end_of_stream, input ready);
	modport sink (input valid, input stream_value, input end_of_stream, output ready);
endinterface

interface mgf_out_if;
	logic        valid;
	logic        ready;
	logic        slot_valid;
	logic [31:0] candidate_value;
	logic [31:0] residual_count;
	logic        last_slot;

	modport source (output valid, output slot_valid, output candidate_value,
		output residual_count, output last_slot, input ready);
	modport sink (input valid, input slot_valid, input candidate_value,
		input residual_count, input last_slot, output ready);
endinterface

[sv/mgf_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgf_cell: one value/counter slot
// Extends the scan token with its own state and applies broadcast commands.
// ----------------------------------------------------------------------------
module mgf_cell #(
	parameter int VALUE_WIDTH = 32,
	parameter int CELL_IDX    = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [VALUE_WIDTH-1:0]  v,
	input  logic                    tok_in_vld,
	input  mgf_pkg::scan_rec_t      tok_in,
	output logic                    tok_out_vld,
	output mgf_pkg::scan_rec_t      tok_out,
	input  mgf_pkg::cell_cmd_t      cmd,
	input  logic [VALUE_WIDTH-1:0]  shift_value,
	input  logic [mgf_pkg::COUNT_W-1:0] shift_count,
	output logic [VALUE_WIDTH-1:0]  value_q,
	output logic [mgf_pkg::COUNT_W-1:0] count_q
);
	import mgf_pkg::*;

	logic      occ;
	logic      match;
	scan_rec_t rec_n;

	assign occ   = (count_q != '0);
	assign match = occ && (value_q == v);

	always_comb begin
		rec_n     = tok_in;
		rec_n.hit = tok_in.hit | match;
		rec_n.occ = tok_in.occ + REC_W'(occ);
		if (!tok_in.free_found && !occ) begin
			rec_n.free_found = 1'b1;
			rec_n.free_idx   = REC_W'(CELL_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out_vld <= 1'b0;
		end else begin
			tok_out_vld <= tok_in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in_vld) begin
			tok_out <= rec_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (cmd.op)
				OP_INC: begin
					if (match && count_q != '1) count_q <= count_q + COUNT_W'(1);
				end
				OP_CLAIM: begin
					if (cmd.idx == REC_W'(CELL_IDX)) count_q <= COUNT_W'(1);
				end
				OP_DEC: begin
					if (occ) count_q <= count_q - COUNT_W'(1);
				end
				OP_SHIFT: begin
					count_q <= shift_count;
				end
				default: begin
					count_q <= count_q;
				end
			endcase
		end
	end

	// slot value carries no reset; it is only read while the count is nonzero
	always_ff @(posedge clk) begin
		if (cmd.op == OP_CLAIM && cmd.idx == REC_W'(CELL_IDX)) begin
			value_q <= v;
		end else if (cmd.op == OP_SHIFT) begin
			value_q <= shift_value;
		end
	end

endmodule

[sv/misra_gries_frequent_items_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// misra_gries_frequent_items_unit: Misra-Gries frequent-items summary
// Row of value/counter cells with a scan token and a readout shift path.
// ----------------------------------------------------------------------------
//  channel | dir | handshake        | item
//  --------+-----+------------------+------------------------------------------
//  stream  | in  | valid/ready      | stream_value, end_of_stream
//  result  | out | valid/ready      | slot_valid, candidate_value,
//          |     |                  | residual_count, last_slot
//  cfg     | in  | cfg_we (no wait) | counters_in_use (cfg_wdata)
//
//  Flow: each item goes through accept, a scan token that walks the cell
//  row one cell per cycle, then an update step. The row length sets how
//  long the scan lasts. An end-of-stream item then drains MAX_COUNTERS
//  result items, one per accepted output handshake; the same shift clears
//  the table. Stream ready is low from accept until the item (and any
//  readout) is done. Reset zeroes all counters and sets the limit to 15.
// ----------------------------------------------------------------------------
module misra_gries_frequent_items_unit #(
	parameter int MAX_COUNTERS = 15,
	parameter int VALUE_WIDTH  = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mgf_in_if.sink                        stream,
	mgf_out_if.source                     result,
	input  logic                          cfg_we,
	input  logic [mgf_pkg::LIMIT_W-1:0]   cfg_wdata
);
	import mgf_pkg::*;

	localparam int IDX_W = (MAX_COUNTERS > 1) ? $clog2(MAX_COUNTERS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_COUNTERS - 1);

	fsm_state_t state_q, state_n;

	logic [LIMIT_W-1:0]     limit_q;
	logic [VALUE_WIDTH-1:0] v_q;
	logic                   eos_q;
	logic                   start_q;
	logic [IDX_W-1:0]       drain_q;

	logic      accept;
	logic      drain_step;
	rec_num_t  limit_eff;
	cell_cmd_t cmd;

	// cell row wiring
	logic                   tok_vld [MAX_COUNTERS+1];
	scan_rec_t              tok     [MAX_COUNTERS+1];
	logic [VALUE_WIDTH-1:0] cell_value [MAX_COUNTERS];
	logic [COUNT_W-1:0]     cell_count [MAX_COUNTERS];

	logic       head_valid;
	logic [63:0] head_value_wide;

	assign accept     = stream.valid && stream.ready;
	assign drain_step = result.valid && result.ready;

	// occupancy limit, clamped to the row length
	assign limit_eff = (REC_W'(limit_q) > REC_W'(MAX_COUNTERS)) ?
		REC_W'(MAX_COUNTERS) : REC_W'(limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// input item capture; only the low VALUE_WIDTH bits of the value count
	always_ff @(posedge clk) begin
		if (accept) begin
			v_q   <= VALUE_WIDTH'(64'(stream.stream_value));
			eos_q <= stream.end_of_stream;
		end
	end

	// token launch pulse into cell 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drain_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q != ST_DRAIN) begin
				drain_q <= '0;
			end else if (drain_step) begin
				drain_q <= drain_q + IDX_W'(1);
			end
		end
	end

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept) state_n = ST_SCAN;
			ST_SCAN:  if (tok_vld[MAX_COUNTERS]) state_n = ST_APPLY;
			ST_APPLY: state_n = eos_q ? ST_DRAIN : ST_IDLE;
			ST_DRAIN: if (drain_step && drain_q == LAST_IDX) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase
	end

	// outputs: handshakes and the command broadcast to the row
	always_comb begin
		stream.ready = 1'b0;
		result.valid = 1'b0;
		cmd.op       = OP_HOLD;
		cmd.idx      = tok[MAX_COUNTERS].free_idx;
		unique case (state_q)
			ST_IDLE: begin
				stream.ready = 1'b1;
			end
			ST_SCAN: begin
			end
			ST_APPLY: begin
				// the final token holds the whole-row verdict
				priority if (tok[MAX_COUNTERS].hit) begin
					cmd.op = OP_INC;
				end else if (tok[MAX_COUNTERS].free_found &&
					tok[MAX_COUNTERS].occ < limit_eff) begin
					cmd.op = OP_CLAIM;
				end else begin
					cmd.op = OP_DEC;
				end
			end
			ST_DRAIN: begin
				result.valid = 1'b1;
				if (drain_step) cmd.op = OP_SHIFT;
			end
			default: begin
			end
		endcase
	end

	assign tok_vld[0] = start_q;
	assign tok[0]     = '{hit: 1'b0, free_found: 1'b0, occ: '0, free_idx: '0};

	// readout shifts toward cell 0; the tail takes a free slot
	genvar gi;
	generate
		for (gi = 0; gi < MAX_COUNTERS; gi++) begin : g_cell
			logic [VALUE_WIDTH-1:0] sh_value;
			logic [COUNT_W-1:0]     sh_count;
			if (gi == MAX_COUNTERS - 1) begin : g_tail
				assign sh_value = cell_value[gi];
				assign sh_count = '0;
			end else begin : g_body
				assign sh_value = cell_value[gi+1];
				assign sh_count = cell_count[gi+1];
			end

			mgf_cell #(
				.VALUE_WIDTH (VALUE_WIDTH),
				.CELL_IDX    (gi)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.v           (v_q),
				.tok_in_vld  (tok_vld[gi]),
				.tok_in      (tok[gi]),
				.tok_out_vld (tok_vld[gi+1]),
				.tok_out     (tok[gi+1]),
				.cmd         (cmd),
				.shift_value (sh_value),
				.shift_count (sh_count),
				.value_q     (cell_value[gi]),
				.count_q     (cell_count[gi])
			);
		end
	endgenerate

	// result payload comes straight from cell 0's registers
	assign head_valid      = (cell_count[0] != '0);
	assign head_value_wide = 64'(cell_value[0]);

	assign result.slot_valid      = head_valid;
	assign result.candidate_value = head_valid ? head_value_wide[PORT_VALUE_W-1:0] : '0;
	assign result.residual_count  = head_valid ? cell_count[0] : '0;
	assign result.last_slot       = (drain_q == LAST_IDX);

endmodule
